>>> rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Types, field widths and codes shared by the piecewise linear correction
// block: item structs, controller to datapath command and status bundles.
// ----------------------------------------------------------------------------
package plc_pkg;

  // configuration registers: one length register per calibration table
  localparam int NUM_LEN_REGS = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 7;

  // table number: NaF tables first, aerogel tables after them
  localparam int             TBL_W        = 3;
  localparam logic [TBL_W-1:0] AGL_TBL_BASE = 3'd3;
  localparam logic [1:0]     QTY_NONE     = 2'd3;
  localparam logic           RAD_NAF      = 1'b1;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // payload widths
  localparam int X_W = 48;
  localparam int Y_W = 32;

  // interpolation arithmetic
  localparam int NUM_W     = X_W + 1;
  localparam int MAG_W     = Y_W;
  localparam int NUM_LO_W  = 25;
  localparam int NUM_HI_W  = NUM_W - NUM_LO_W;
  localparam int PL_W      = NUM_LO_W + MAG_W;
  localparam int PH_W      = NUM_HI_W + MAG_W;
  localparam int PROD_W    = NUM_W + MAG_W;
  localparam int QUO_W     = MAG_W;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  // 1.0 in Q8.24
  localparam logic [Y_W-1:0] ONE_Q24 = 32'h0100_0000;

  typedef enum logic [1:0] {
    KIND_INTERP   = 2'd0,
    KIND_CLAMP_LO = 2'd1,
    KIND_CLAMP_HI = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  // which breakpoint of the selected table the read port fetches
  typedef enum logic [1:0] {
    RD_FIRST  = 2'd0,
    RD_LAST   = 2'd1,
    RD_SECOND = 2'd2,
    RD_NEXT   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic                  mode;
    logic                  radiator;
    logic [1:0]            quantity;
    logic [5:0]            entry_index;
    logic signed [X_W-1:0] x_value;
    logic signed [Y_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [Y_W-1:0] correction;
    logic [1:0]            result_kind;
  } out_item_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    save_prev;
    logic    scan_init;
    logic    scan_step;
    logic    setup;
    logic    mul;
    logic    sum;
    logic    div_start;
    logic    emit;
    kind_t   kind;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic lo_hit;
    logic hi_hit;
    logic found;
    logic div_done;
  } dp_stat_t;

endpackage

>>> rtl/plc_ctrl.sv
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer for the correction block: accepts items, walks a query through
// the end checks, the breakpoint scan, the multiply and the divide.
// ----------------------------------------------------------------------------
module plc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_mode,
  output logic              busy,
  output logic              out_valid,
  output plc_pkg::dp_cmd_t  cmd,
  input  plc_pkg::dp_stat_t stat
);
  import plc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHK_LO,
    S_CHK_HI,
    S_SCAN,
    S_MUL,
    S_SUM,
    S_DIV_GO,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  // next state and datapath commands
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_FIRST;
    cmd.kind      = KIND_INTERP;
    cmd.accept    = accept;
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_QUERY)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.len_zero) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FIRST;
          state_nxt  = S_CHK_LO;
        end
      end
      S_CHK_LO: begin
        if (stat.lo_hit) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_CLAMP_LO;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LAST;
          cmd.save_prev = 1'b1;
          state_nxt     = S_CHK_HI;
        end
      end
      S_CHK_HI: begin
        if (stat.hi_hit) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_CLAMP_HI;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_SECOND;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.found) begin
          cmd.setup = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_INTERP;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt      = (state_nxt != S_IDLE);
    out_valid_nxt = cmd.emit;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/plc_div.sv
// ----------------------------------------------------------------------------
// plc_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in QUO_W bits, so the upper dividend bits start as the remainder.
// ----------------------------------------------------------------------------
module plc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plc_pkg::PROD_W-1:0]  dividend,
  input  logic [plc_pkg::NUM_W-1:0]   divisor,
  output logic                        done,
  output logic [plc_pkg::QUO_W-1:0]   quotient
);
  import plc_pkg::*;

  logic [NUM_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     low_r, low_nxt;
  logic [NUM_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [NUM_W:0]       trial;
  logic                 ge;

  // one shift-subtract step; quotient bits enter low_r as dividend bits leave
  always_comb begin
    trial   = {rem_r, low_r[QUO_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? NUM_W'(trial - {1'b0, div_r}) : NUM_W'(trial);
    low_nxt = {low_r[QUO_W-2:0], ge};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(QUO_W);
    end else if (run_r) begin
      cnt_r  <= cnt_r - DIV_CNT_W'(1);
      run_r  <= (cnt_r != DIV_CNT_W'(1));
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PROD_W-1:QUO_W];
      low_r <= dividend[QUO_W-1:0];
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = low_r;

endmodule

>>> rtl/plc_dp.sv
// ----------------------------------------------------------------------------
// plc_dp
// Datapath: length registers, breakpoint memories, scan registers, split
// multiplier, divider and the result register.
// ----------------------------------------------------------------------------
module plc_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int TABLE_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  plc_pkg::in_item_t              in_item,
  input  plc_pkg::dp_cmd_t               cmd,
  output plc_pkg::dp_stat_t              stat,
  output plc_pkg::out_item_t             out_item
);
  import plc_pkg::*;

  localparam int DEPTH_ALL = TABLE_COUNT * TABLE_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);
  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int LW        = $clog2(TABLE_DEPTH + 1);
  localparam int LCW       = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

  // length registers
  logic [CFG_DATA_W-1:0] len_r [NUM_LEN_REGS];

  // breakpoint memories
  logic [X_W-1:0] mem_x [DEPTH_ALL];
  logic [Y_W-1:0] mem_y [DEPTH_ALL];

  logic [TBL_W-1:0]      in_tbl;
  logic                  in_tbl_ok;
  logic [CFG_DATA_W-1:0] len_sel;
  logic [LCW-1:0]        len_ext;
  logic [LCW-1:0]        len_eff;
  logic                  wr_ok;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         base;

  logic signed [X_W-1:0] x_q_r;
  logic [AW-1:0]         base_r;
  logic                  len_zero_r;
  logic [IW-1:0]         len_m1_r;

  logic [IW-1:0]         idx_r;
  logic [IW-1:0]         rd_idx;
  logic [AW-1:0]         rd_addr;
  logic signed [X_W-1:0] rdx_r, prev_x_r;
  logic signed [Y_W-1:0] rdy_r, prev_y_r;

  logic [NUM_W-1:0]      num_r, den_r;
  logic [MAG_W-1:0]      mag_r;
  logic                  neg_r;
  logic signed [Y_W-1:0] y0_r;
  logic [PL_W-1:0]       pl_r;
  logic [PH_W-1:0]       ph_r;
  logic [PROD_W-1:0]     prod_r;

  logic                  div_done;
  logic [QUO_W-1:0]      quo;
  logic [Y_W-1:0]        interp;
  out_item_t             out_item_r;

  // table number and effective length of the incoming item
  always_comb begin
    if (in_item.radiator == RAD_NAF) begin
      in_tbl = {1'b0, in_item.quantity};
    end else begin
      in_tbl = TBL_W'(in_item.quantity) + AGL_TBL_BASE;
    end
    in_tbl_ok = (in_item.quantity != QTY_NONE) && (32'(in_tbl) < 32'(TABLE_COUNT));
    len_sel   = in_tbl_ok ? len_r[in_tbl] : '0;
    len_ext   = LCW'(len_sel);
    len_eff   = (len_ext > LCW'(TABLE_DEPTH)) ? LCW'(TABLE_DEPTH) : len_ext;
    base      = AW'(in_tbl) * AW'(TABLE_DEPTH);
    wr_addr   = base + AW'(in_item.entry_index);
    wr_ok     = cmd.accept && (in_item.mode == MODE_LOAD) && in_tbl_ok &&
                (32'(in_item.entry_index) < 32'(TABLE_DEPTH));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEN_REGS; i++) begin
        len_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < 32'(NUM_LEN_REGS))) begin
      len_r[cfg_index] <= cfg_data;
    end
  end

  // capture of a query
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_q_r      <= in_item.x_value;
      base_r     <= base;
      len_zero_r <= (len_eff == '0);
      len_m1_r   <= IW'(len_eff - LCW'(1));
    end
  end

  // read index selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_FIRST:  rd_idx = '0;
      RD_LAST:   rd_idx = len_m1_r;
      RD_SECOND: rd_idx = IW'(1);
      RD_NEXT:   rd_idx = idx_r + IW'(1);
      default:   rd_idx = '0;
    endcase
    rd_addr = base_r + AW'(rd_idx);
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_x[wr_addr] <= in_item.x_value;
      mem_y[wr_addr] <= in_item.y_value;
    end
    if (cmd.rd_en) begin
      rdx_r <= mem_x[rd_addr];
      rdy_r <= mem_y[rd_addr];
    end
  end

  // scan index and previous breakpoint
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r <= IW'(1);
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.save_prev || cmd.scan_step) begin
      prev_x_r <= rdx_r;
      prev_y_r <= rdy_r;
    end
  end

  // interval setup, partial products and their sum
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      num_r <= {x_q_r[X_W-1], x_q_r} - {prev_x_r[X_W-1], prev_x_r};
      den_r <= {rdx_r[X_W-1], rdx_r} - {prev_x_r[X_W-1], prev_x_r};
      neg_r <= (rdy_r < prev_y_r);
      mag_r <= (rdy_r < prev_y_r) ? MAG_W'(prev_y_r - rdy_r) : MAG_W'(rdy_r - prev_y_r);
      y0_r  <= prev_y_r;
    end
    if (cmd.mul) begin
      pl_r <= num_r[NUM_LO_W-1:0] * mag_r;
      ph_r <= num_r[NUM_W-1:NUM_LO_W] * mag_r;
    end
    if (cmd.sum) begin
      prod_r <= {ph_r, {NUM_LO_W{1'b0}}} + PROD_W'(pl_r);
    end
  end

  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // result value
  assign interp = neg_r ? (Y_W'(y0_r) - quo) : (Y_W'(y0_r) + quo);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.result_kind <= cmd.kind;
      unique case (cmd.kind)
        KIND_EMPTY:    out_item_r.correction <= ONE_Q24;
        KIND_CLAMP_LO: out_item_r.correction <= rdy_r;
        KIND_CLAMP_HI: out_item_r.correction <= rdy_r;
        KIND_INTERP:   out_item_r.correction <= interp;
        default:       out_item_r.correction <= interp;
      endcase
    end
  end

  // status to the sequencer
  always_comb begin
    stat.len_zero = len_zero_r;
    stat.lo_hit   = (x_q_r <= rdx_r);
    stat.hi_hit   = (x_q_r >= rdx_r);
    stat.found    = (rdx_r >= x_q_r) || (idx_r == len_m1_r);
    stat.div_done = div_done;
  end

  assign out_item = out_item_r;

endmodule

>>> rtl/piecewise_linear_correction.sv
// ----------------------------------------------------------------------------
// piecewise_linear_correction
// Six calibration tables of (x, y) breakpoints with a linear interpolating
// query. An item is taken when start is high and busy is low. A load item
// (mode 0) writes one breakpoint in that cycle and gives no result; busy
// stays low, so loads can follow every cycle. A query item (mode 1) raises
// busy and gives one result on out_item, marked by a one-cycle out_valid.
// A query ends at the empty or low or high end check that hits; else a
// linear scan reads k breakpoints (1 to len-1), one per cycle through the
// single read port, and the multiply and bit-serial divider interpolate.
// busy drops in the cycle that shows the result, so a new item can be
// taken there. The receiver cannot stall the result. Length registers
// must be written by the user through cfg_we / cfg_index / cfg_data only
// while idle; the block does not enforce it. Reset clears the lengths and
// the sequencer; breakpoint memories are not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_correction #(
  parameter int TABLE_DEPTH = 64,
  parameter int TABLE_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  plc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output plc_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_item.mode),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  plc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TABLE_COUNT (TABLE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

>>> rtl/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the correction block, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input plc_pkg::in_item_t  in_item,
  input logic               out_valid,
  input plc_pkg::out_item_t out_item
);
  import plc_pkg::*;

  // an accepted query raises busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_QUERY)) |=> busy)
    else $error("query item did not raise busy");

  // a load item gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == MODE_LOAD)) |=> (!out_valid && !busy))
    else $error("load item gave a result or raised busy");

  // a result is shown as the block goes idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // one query gives one result strobe
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // empty table answers 1.0
  a_empty_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.result_kind == KIND_EMPTY)) |->
      (out_item.correction == ONE_Q24))
    else $error("empty table result is not 1.0");

endmodule

bind piecewise_linear_correction plc_checker u_plc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> tb/piecewise_linear_correction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_correction_tb
// Self-checking bench for the six-table breakpoint interpolator. Load and
// query items are queued by the stimulus process and sent by a driver with
// random idle gaps. A local model of the tables and length registers
// predicts every query result, and the monitor compares each strobed result
// against the oldest prediction. A short directed set covers the table ends,
// extreme breakpoints and unsorted tables; random phases then reprogram the
// lengths and refill the tables.
// ----------------------------------------------------------------------------
module piecewise_linear_correction_tb;
  import plc_pkg::*;

  localparam int     TB_TABLES      = 6;
  localparam int     TB_DEPTH       = 64;
  localparam longint Q16            = 65536;
  localparam int     RANDOM_ITEMS   = 650;
  localparam int     LOAD_SETTLE    = 8;
  localparam int     END_SETTLE     = 110;
  localparam int     WATCHDOG_LIMIT = 2000;

  // table numbers, equal to the index of the matching length register
  localparam int TBL_NAF_THETA = 0;
  localparam int TBL_NAF_PHI   = 1;
  localparam int TBL_NAF_TIME  = 2;
  localparam int TBL_AGL_THETA = 3;
  localparam int TBL_AGL_PHI   = 4;
  localparam int TBL_AGL_TIME  = 5;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // model of the block, updated at each accepted item
  logic signed [X_W-1:0]  bp_x [TB_TABLES][TB_DEPTH];
  logic signed [Y_W-1:0]  bp_y [TB_TABLES][TB_DEPTH];
  logic [CFG_DATA_W-1:0]  len_reg [TB_TABLES];
  out_item_t              correction_q [$];

  // stimulus-side view of table contents, as of the items queued so far
  longint                 gen_x   [TB_TABLES][TB_DEPTH];
  bit                     gen_wr  [TB_TABLES][TB_DEPTH];
  int                     gen_len [TB_TABLES];

  in_item_t item_q [$];
  int       stim_count   = 0;
  int       fail_count   = 0;
  int       quiet_cycles = 0;
  int       gap_left     = 0;
  bit       no_idle      = 1'b0;
  bit       accept_seen  = 1'b0;

  piecewise_linear_correction u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // table number from radiator and quantity, -1 for no table
  function automatic int table_num(logic rad, logic [1:0] qty);
    if (qty == QTY_NONE) return -1;
    return (rad == RAD_NAF) ? int'(qty) : int'(AGL_TBL_BASE) + int'(qty);
  endfunction

  // lengths above the table depth count as the full table
  function automatic int eff_len(int v);
    return (v > TB_DEPTH) ? TB_DEPTH : v;
  endfunction

  // expected result of one query against the modeled tables
  function automatic out_item_t predict_correction(in_item_t it);
    out_item_t   r;
    int          tn, n, i;
    longint      xq, x0, x1, y0, y1, dy, yv;
    logic [63:0] num, den, mag;
    logic [127:0] quo;
    tn = table_num(it.radiator, it.quantity);
    n  = (tn >= 0) ? eff_len(len_reg[tn]) : 0;
    xq = $signed(it.x_value);
    r.correction  = ONE_Q24;
    r.result_kind = KIND_EMPTY;
    if (n == 0) return r;
    x0 = bp_x[tn][0];
    if (xq <= x0) begin
      r.correction  = bp_y[tn][0];
      r.result_kind = KIND_CLAMP_LO;
      return r;
    end
    x1 = bp_x[tn][n-1];
    if (xq >= x1) begin
      r.correction  = bp_y[tn][n-1];
      r.result_kind = KIND_CLAMP_HI;
      return r;
    end
    // first breakpoint from index one up that is not below x
    i = 1;
    while (i < n - 1 && bp_x[tn][i] < xq) i++;
    x0  = bp_x[tn][i-1];
    x1  = bp_x[tn][i];
    y0  = bp_y[tn][i-1];
    y1  = bp_y[tn][i];
    dy  = y1 - y0;
    num = xq - x0;
    den = x1 - x0;
    mag = (dy < 0) ? -dy : dy;
    // exact product and quotient, magnitude truncated toward zero
    quo = ({64'd0, num} * {64'd0, mag}) / {64'd0, den};
    yv  = (dy < 0) ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
    r.correction  = yv[Y_W-1:0];
    r.result_kind = KIND_INTERP;
    return r;
  endfunction

  // apply a load to the modeled tables or queue the predicted correction
  task automatic absorb_item(in_item_t it);
    int tn;
    tn = table_num(it.radiator, it.quantity);
    if (it.mode == MODE_LOAD) begin
      if (tn >= 0) begin
        bp_x[tn][it.entry_index] = it.x_value;
        bp_y[tn][it.entry_index] = it.y_value;
      end
    end else begin
      correction_q = {correction_q, predict_correction(it)};
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // item aimed at table t, all other fields random
  function automatic in_item_t table_item(int t, logic mode);
    in_item_t    it;
    logic [95:0] r96;
    r96 = {$urandom, $urandom, $urandom};
    it  = r96[$bits(in_item_t)-1:0];
    it.mode = mode;
    if (t >= int'(AGL_TBL_BASE)) begin
      it.radiator = ~RAD_NAF;
      it.quantity = 2'(t - int'(AGL_TBL_BASE));
    end else begin
      it.radiator = RAD_NAF;
      it.quantity = 2'(t);
    end
    return it;
  endfunction

  function automatic bit table_ready(int t);
    for (int k = 0; k < eff_len(gen_len[t]); k++)
      if (!gen_wr[t][k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_item(in_item_t it);
    int tn;
    tn = table_num(it.radiator, it.quantity);
    if (it.mode == MODE_LOAD && tn >= 0) begin
      gen_x[tn][it.entry_index]  = $signed(it.x_value);
      gen_wr[tn][it.entry_index] = 1'b1;
    end
    // loads into no table are dropped by the block and not counted
    if (it.mode == MODE_QUERY || tn >= 0) stim_count++;
    item_q = {item_q, it};
  endtask

  task automatic load_entry(int t, int idx, longint x, logic [31:0] y);
    in_item_t it;
    it = table_item(t, MODE_LOAD);
    it.entry_index = idx[5:0];
    it.x_value     = x[X_W-1:0];
    it.y_value     = y;
    queue_item(it);
  endtask

  task automatic ask(int t, longint x);
    in_item_t it;
    it = table_item(t, MODE_QUERY);
    it.x_value = x[X_W-1:0];
    queue_item(it);
  endtask

  task automatic ask_no_table(logic mode);
    in_item_t it;
    it = table_item($urandom_range(0, TB_TABLES - 1), mode);
    it.quantity = QTY_NONE;
    queue_item(it);
  endtask

  // wait until the driver is done and every result has come back
  task automatic wait_quiet(int settle);
    forever begin
      @(posedge clk);
      #2;
      if (item_q.size() == 0 && !start && correction_q.size() == 0) break;
    end
    repeat (settle) @(posedge clk);
  endtask

  // write all length registers from gen_len while the block is idle
  task automatic program_lengths();
    wait_quiet(LOAD_SETTLE);
    for (int t = 0; t < TB_TABLES; t++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= t[CFG_IDX_W-1:0];
      cfg_data  <= gen_len[t][CFG_DATA_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // write entries 0..n-1, sorted by x unless scrambled
  task automatic fill_table(int t, int n, bit scrambled);
    longint      xv;
    logic [63:0] r;
    logic [31:0] yv;
    int          sh;
    r  = rand64();
    xv = $signed(r[45:0]);
    sh = $urandom_range(0, 40);
    for (int k = 0; k < n; k++) begin
      r = rand64();
      if ($urandom_range(0, 1)) yv = $urandom;
      else yv = ONE_Q24 + $urandom_range(0, 1 << 20) - (1 << 19);
      if (scrambled) xv = $signed(r[47:0]);
      else if (k > 0 && $urandom_range(0, 19) != 0) xv += 1 + longint'(r % (64'd1 << sh));
      load_entry(t, k, xv, yv);
    end
  endtask

  // query position around the breakpoints of table t
  function automatic longint pick_x(int t);
    int          n, k, r;
    longint      a, b;
    logic [63:0] w;
    n = eff_len(gen_len[t]);
    w = rand64();
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) return $signed(w[47:0]);
    k = $urandom_range(0, n - 1);
    a = gen_x[t][k];
    if (r < 20) return gen_x[t][0] - $urandom_range(0, 1000);
    if (r < 30) return gen_x[t][n-1] + $urandom_range(0, 1000);
    if (r < 45) return a;
    if (r < 55) return $urandom_range(0, 1) ? a + 1 : a - 1;
    if (k == n - 1) return a;
    b = gen_x[t][k+1];
    if (b <= a) return a;
    return a + longint'(w % (b - a + 1));
  endfunction

  // new lengths, table refills, then a mix of queries and noise
  task automatic random_phase();
    int t, r, n, nq;
    for (t = 0; t < TB_TABLES; t++) begin
      r = $urandom_range(0, 99);
      if (r < 15) gen_len[t] = 0;
      else if (r < 25) gen_len[t] = 1;
      else if (r < 35) gen_len[t] = 2;
      else if (r < 75) gen_len[t] = $urandom_range(3, 10);
      else if (r < 88) gen_len[t] = $urandom_range(11, 63);
      else if (r < 94) gen_len[t] = TB_DEPTH;
      else gen_len[t] = $urandom_range(TB_DEPTH + 1, 127);
    end
    program_lengths();
    for (t = 0; t < TB_TABLES; t++) begin
      n = eff_len(gen_len[t]);
      if (n > 0 && (!table_ready(t) || $urandom_range(0, 3) != 0))
        fill_table(t, n, $urandom_range(0, 9) == 0);
    end
    nq = $urandom_range(20, 50);
    repeat (nq) begin
      r = $urandom_range(0, 99);
      t = $urandom_range(0, TB_TABLES - 1);
      if (r < 5) ask_no_table(MODE_LOAD);
      else if (r < 10) ask_no_table(MODE_QUERY);
      else if (r < 18) load_entry(t, $urandom_range(0, TB_DEPTH - 1), pick_x(t), $urandom);
      else if (eff_len(gen_len[t]) == 0 || table_ready(t)) ask(t, pick_x(t));
    end
  endtask

  // driver: one item at a time from item_q, random idle gaps between items
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accept_seen) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (item_q.size() != 0) begin
        in_item <= item_q.pop_front();
        start   <= 1'b1;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        if (no_idle) gap_left = 0;
        else begin
          case ($urandom_range(0, 99)) inside
            [0:54]:  gap_left = 0;
            [55:89]: gap_left = $urandom_range(1, 3);
            [90:97]: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: register writes, accepted items, result check, watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      accept_seen  = 1'b0;
      quiet_cycles = 0;
      for (int t = 0; t < TB_TABLES; t++) len_reg[t] = '0;
    end else begin
      accept_seen = start && !busy;
      if (cfg_we && cfg_index < TB_TABLES) len_reg[cfg_index] = cfg_data;
      if (out_valid) begin
        if (correction_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none actual %h/%0d", $time,
                   out_item.correction, out_item.result_kind);
        end else begin
          want = correction_q.pop_front();
          if (out_item.correction !== want.correction) begin
            fail_count++;
            $display("%0t correction mismatch: expected %h actual %h", $time,
                     want.correction, out_item.correction);
          end
          if (out_item.result_kind !== want.result_kind) begin
            fail_count++;
            $display("%0t result_kind mismatch: expected %0d actual %0d", $time,
                     want.result_kind, out_item.result_kind);
          end
        end
      end
      if (accept_seen) absorb_item(in_item);
      if (accept_seen || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no item accepted for %0d cycles", $time, quiet_cycles);
        $display("piecewise_linear_correction regression: fail");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: clamps, exact breakpoints, extremes, unsorted scan, no table
    gen_len[TBL_NAF_THETA] = 3;
    gen_len[TBL_NAF_PHI]   = 1;
    gen_len[TBL_NAF_TIME]  = 0;
    gen_len[TBL_AGL_THETA] = 2;
    gen_len[TBL_AGL_PHI]   = 0;
    gen_len[TBL_AGL_TIME]  = 4;
    program_lengths();
    load_entry(TBL_NAF_THETA, 0, -100 * Q16, 32'h0200_0000);
    load_entry(TBL_NAF_THETA, 1, 0,          32'h0100_0000);
    load_entry(TBL_NAF_THETA, 2, 100 * Q16,  32'hFF00_0000);
    load_entry(TBL_NAF_PHI,   0, 5 * Q16,    32'h7FFF_FFFF);
    load_entry(TBL_AGL_THETA, 0, -(longint'(1) <<< 47),    32'h8000_0000);
    load_entry(TBL_AGL_THETA, 1, (longint'(1) <<< 47) - 1, 32'h7FFF_FFFF);
    load_entry(TBL_AGL_TIME,  0, 0,          ONE_Q24);
    load_entry(TBL_AGL_TIME,  1, -10 * Q16,  32'h0040_0000);
    load_entry(TBL_AGL_TIME,  2, 20 * Q16,   32'hC000_0000);
    load_entry(TBL_AGL_TIME,  3, 30 * Q16,   32'h0200_0000);
    ask_no_table(MODE_LOAD);
    ask(TBL_NAF_THETA, -200 * Q16);
    ask(TBL_NAF_THETA, -100 * Q16);
    ask(TBL_NAF_THETA, -50 * Q16 + 3);
    ask(TBL_NAF_THETA, 0);
    ask(TBL_NAF_THETA, 50 * Q16 + 7);
    ask(TBL_NAF_THETA, 100 * Q16);
    ask(TBL_NAF_THETA, 300 * Q16);
    ask(TBL_NAF_PHI, 5 * Q16);
    ask(TBL_NAF_PHI, 6 * Q16);
    ask(TBL_NAF_TIME, 1 * Q16);
    ask_no_table(MODE_QUERY);
    ask(TBL_AGL_THETA, 0);
    ask(TBL_AGL_THETA, (longint'(1) <<< 47) - 2);
    ask(TBL_AGL_TIME, 5 * Q16);

    // random phases until enough items have been queued
    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) random_phase();

    wait_quiet(END_SETTLE);
    if (fail_count == 0) begin
      $display("piecewise_linear_correction regression: pass");
    end else begin
      $display("piecewise_linear_correction regression: fail");
    end
    $finish;
  end

endmodule

>>> piecewise_linear_correction.f
rtl/plc_pkg.sv
rtl/plc_ctrl.sv
rtl/plc_div.sv
rtl/plc_dp.sv
rtl/piecewise_linear_correction.sv
rtl/plc_checker.sv
tb/piecewise_linear_correction_tb.sv
